@@ rtl/core/crmn_pkg.sv @@
package crmn_pkg;

  // geometry limits
  localparam int unsigned MaxColumns = 256;
  localparam int unsigned MaxRows    = 256;
  localparam int unsigned MaxSlices  = 64;
  localparam int unsigned ColW       = $clog2(MaxColumns);
  localparam int unsigned RowW       = $clog2(MaxRows);
  localparam int unsigned SlcW       = $clog2(MaxSlices);

  // fixed point constants
  localparam logic signed [31:0] FactorOne = 32'sh0100_0000;
  localparam logic [40:0]        QuotCap   = 41'h100_0000_0000;
  localparam logic [6:0]         DivSteps  = 7'd87;

  // register indexes
  localparam logic [2:0] RegSizeX    = 3'd0;
  localparam logic [2:0] RegSizeY    = 3'd1;
  localparam logic [2:0] RegSizeZ    = 3'd2;
  localparam logic [2:0] RegComplex  = 3'd3;
  localparam logic [2:0] RegAllowNeg = 3'd4;

  typedef enum logic [1:0] {
    MODE_REF   = 2'd0,
    MODE_MEAS  = 2'd1,
    MODE_SCALE = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_ALL_MISSING = 2'd1,
    ST_NEG_MEAN    = 2'd2,
    ST_ZERO_MEAN   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_MUL_A,
    S_MUL_B,
    S_MUL_C,
    S_SQRT,
    S_PREP,
    S_ACC,
    S_JUDGE,
    S_DIV,
    S_DIV_END,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [8:0] size_x;
    logic [8:0] size_y;
    logic [6:0] size_z;
    logic       complex_samples;
    logic       allow_negative_mean;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul_re;
    logic mul_im;
    logic take_a;
    logic take_b;
    logic sqrt_step;
    logic prep;
    logic acc;
    logic judge_fix;
    logic div_start;
    logic div_step;
    logic div_end;
    logic emit;
  } cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  last;
    logic  complex_samples;
    logic  sqrt_last;
    logic  judge_ok;
    logic  div_last;
    logic  out_free;
  } sts_t;

endpackage

@@ rtl/core/crmn_ctrl.sv @@
module crmn_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  crmn_pkg::sts_t sts_i,
  output crmn_pkg::cmd_t cmd_o
);
  import crmn_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (in_valid_i) state_d = S_DISPATCH;
      S_DISPATCH: begin
        unique case (sts_i.mode)
          MODE_NONE:  state_d = S_IDLE;
          MODE_SCALE: state_d = S_MUL_A;
          default:    state_d = sts_i.complex_samples ? S_MUL_A : S_PREP;
        endcase
      end
      S_MUL_A:    state_d = S_MUL_B;
      S_MUL_B:    state_d = S_MUL_C;
      S_MUL_C:    state_d = (sts_i.mode == MODE_SCALE) ? S_EMIT : S_SQRT;
      S_SQRT:     if (sts_i.sqrt_last) state_d = S_PREP;
      S_PREP:     state_d = S_ACC;
      S_ACC:      state_d = (sts_i.mode == MODE_MEAS && sts_i.last) ? S_JUDGE : S_IDLE;
      S_JUDGE:    state_d = sts_i.judge_ok ? S_DIV : S_EMIT;
      S_DIV:      if (sts_i.div_last) state_d = S_DIV_END;
      S_DIV_END:  state_d = S_EMIT;
      S_EMIT:     if (sts_i.out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // command strobes
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i;
      end
      S_MUL_A:   cmd_o.mul_re = 1'b1;
      S_MUL_B: begin
        cmd_o.mul_im = 1'b1;
        cmd_o.take_a = 1'b1;
      end
      S_MUL_C:   cmd_o.take_b = 1'b1;
      S_SQRT:    cmd_o.sqrt_step = 1'b1;
      S_PREP:    cmd_o.prep = 1'b1;
      S_ACC:     cmd_o.acc = 1'b1;
      S_JUDGE: begin
        cmd_o.div_start = sts_i.judge_ok;
        cmd_o.judge_fix = !sts_i.judge_ok;
      end
      S_DIV:     cmd_o.div_step = 1'b1;
      S_DIV_END: cmd_o.div_end = 1'b1;
      S_EMIT:    cmd_o.emit = sts_i.out_free;
      default:   cmd_o = '0;
    endcase
  end

endmodule

@@ rtl/core/crmn_datapath.sv @@
module crmn_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  crmn_pkg::cmd_t        cmd_i,
  output crmn_pkg::sts_t        sts_o,
  input  crmn_pkg::cfg_t        cfg_i,
  input  crmn_pkg::mode_e       mode_i,
  input  logic signed [31:0]    sample_real_i,
  input  logic signed [31:0]    sample_imag_i,
  input  logic [63:0]           slice_missing_mask_i,
  input  logic                  last_voxel_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  result_kind_o,
  output logic signed [31:0]    scaled_real_o,
  output logic signed [31:0]    scaled_imag_o,
  output logic signed [31:0]    scale_factor_o,
  output crmn_pkg::status_e     status_o
);
  import crmn_pkg::*;

  function automatic logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  // round product to Q16.16, ties away from zero, saturate
  function automatic logic signed [31:0] round_sat(logic signed [63:0] p);
    logic [63:0] m;
    logic [63:0] r;
    logic        neg;
    m   = p[63] ? (64'd0 - p) : p;
    neg = p[63];
    r   = (m + 64'd8388608) >> 24;
    if (!neg && r > 64'h7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (neg && r > 64'h8000_0000) return 32'sh8000_0000;
    return neg ? 32'(64'd0 - r) : r[31:0];
  endfunction

  // latched item
  mode_e              mode_q;
  logic signed [31:0] re_q, im_q;
  logic [63:0]        mask_q;
  logic               last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      re_q   <= sample_real_i;
      im_q   <= cfg_i.complex_samples ? sample_imag_i : 32'sd0;
      mask_q <= slice_missing_mask_i;
      last_q <= last_voxel_i;
    end
  end

  // effective sizes and box limits
  logic [8:0]  sx, sy;
  logic [6:0]  sz;
  logic [10:0] x3, x5, y3, y5;
  logic [8:0]  z3, z5;
  logic [ColW-1:0] x0, x1;
  logic [RowW-1:0] y0, y1;
  logic [SlcW-1:0] z0, z1;

  always_comb begin
    sx = (cfg_i.size_x == 9'd0) ? 9'd1 : ((cfg_i.size_x > 9'd256) ? 9'd256 : cfg_i.size_x);
    sy = (cfg_i.size_y == 9'd0) ? 9'd1 : ((cfg_i.size_y > 9'd256) ? 9'd256 : cfg_i.size_y);
    sz = (cfg_i.size_z == 7'd0) ? 7'd1 : ((cfg_i.size_z > 7'd64) ? 7'd64 : cfg_i.size_z);
    x3 = 11'({2'b0, sx} * 11'd3);
    x5 = 11'({2'b0, sx} * 11'd5);
    y3 = 11'({2'b0, sy} * 11'd3);
    y5 = 11'({2'b0, sy} * 11'd5);
    z3 = 9'({2'b0, sz} * 9'd3);
    z5 = 9'({2'b0, sz} * 9'd5);
    x0 = x3[10:3];
    x1 = x5[10:3];
    y0 = y3[10:3];
    y1 = y5[10:3];
    z0 = z3[8:3];
    z1 = z5[8:3];
  end

  // shared multiplier with registered product
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_q;
  logic signed [31:0] factor_q;

  assign mul_a = cmd_i.mul_im ? im_q : re_q;
  assign mul_b = (mode_q == MODE_SCALE) ? factor_q : mul_a;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_re || cmd_i.mul_im) prod_q <= mul_a * mul_b;
  end

  // scaled results and squared magnitude
  logic signed [31:0] res_re_q, res_im_q;
  logic [63:0]        sq_a_q;
  logic [63:0]        sq_n_q, sq_res_q, sq_bit_q;
  logic [63:0]        sq_t;

  assign sq_t = sq_res_q + sq_bit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_a) begin
      if (mode_q == MODE_SCALE) res_re_q <= round_sat(prod_q);
      else sq_a_q <= prod_q;
    end
    if (cmd_i.take_b) begin
      if (mode_q == MODE_SCALE) begin
        res_im_q <= round_sat(prod_q);
      end else begin
        sq_n_q   <= sq_a_q + prod_q;
        sq_res_q <= '0;
        sq_bit_q <= 64'h4000_0000_0000_0000;
      end
    end
    // one result bit of the integer square root
    if (cmd_i.sqrt_step) begin
      if (sq_n_q >= sq_t) begin
        sq_n_q   <= sq_n_q - sq_t;
        sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
      end else begin
        sq_res_q <= sq_res_q >> 1;
      end
      sq_bit_q <= sq_bit_q >> 2;
    end
  end

  logic signed [63:0] val;
  assign val = cfg_i.complex_samples ? {32'd0, sq_res_q[31:0]} : 64'(re_q);

  // position, slice sum store and running sums
  logic [ColW-1:0] col_q, col_n;
  logic [RowW-1:0] row_q, row_n;
  logic [SlcW-1:0] slc_q, slc_n;
  logic            at_start;
  logic [MaxSlices-1:0] vld_q;
  logic [63:0]     mem [MaxSlices];
  logic signed [63:0] rd_q;
  logic            rd_vld_q;
  logic signed [63:0] ref_cur;
  logic signed [63:0] msum_q, rsum_q;
  logic            inbox;
  logic [8:0]      col_inc, row_inc;
  logic [6:0]      slc_inc;

  always_comb begin
    col_n    = ({1'b0, col_q} >= sx) ? '0 : col_q;
    row_n    = ({1'b0, row_q} >= sy) ? '0 : row_q;
    slc_n    = ({1'b0, slc_q} >= sz) ? '0 : slc_q;
    at_start = (col_n == '0) && (row_n == '0) && (slc_n == '0);
    ref_cur  = rd_vld_q ? rd_q : 64'sd0;
    inbox    = (col_q >= x0) && (col_q <= x1) && (row_q >= y0) && (row_q <= y1) &&
               (slc_q >= z0) && (slc_q <= z1);
    col_inc  = {1'b0, col_q} + 9'd1;
    row_inc  = {1'b0, row_q} + 9'd1;
    slc_inc  = {1'b0, slc_q} + 7'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      slc_q    <= '0;
      vld_q    <= '0;
      msum_q   <= '0;
      rsum_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      // restart check and clears for a new pass
      if (cmd_i.prep) begin
        col_q    <= col_n;
        row_q    <= row_n;
        slc_q    <= slc_n;
        rd_vld_q <= vld_q[slc_n] && !(at_start && mode_q == MODE_REF);
        if (at_start && mode_q == MODE_REF) vld_q <= '0;
        if (at_start && mode_q == MODE_MEAS) begin
          msum_q <= '0;
          rsum_q <= '0;
        end
      end
      if (cmd_i.acc) begin
        if (mode_q == MODE_REF && inbox) vld_q[slc_q] <= 1'b1;
        if (mode_q == MODE_MEAS && inbox && !mask_q[slc_q]) begin
          msum_q <= sat_add(msum_q, val);
          if (col_q == x0 && row_q == y0) rsum_q <= sat_add(rsum_q, ref_cur);
        end
        // step column, row, slice
        if (last_q) begin
          col_q <= '0;
          row_q <= '0;
          slc_q <= '0;
        end else if (col_inc < sx) begin
          col_q <= col_inc[ColW-1:0];
        end else begin
          col_q <= '0;
          if (row_inc < sy) begin
            row_q <= row_inc[RowW-1:0];
          end else begin
            row_q <= '0;
            slc_q <= (slc_inc < sz) ? slc_inc[SlcW-1:0] : '0;
          end
        end
      end
    end
  end

  // slice sum memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) rd_q <= mem[slc_n];
    if (cmd_i.acc && mode_q == MODE_REF && inbox) mem[slc_q] <= sat_add(ref_cur, val);
  end

  // outcome classification
  logic [MaxSlices-1:0] boxmask;
  status_e judge;

  always_comb begin
    for (int k = 0; k < MaxSlices; k++) begin
      boxmask[k] = (SlcW'(k) >= z0) && (SlcW'(k) <= z1);
    end
    if ((mask_q & boxmask) == boxmask) judge = ST_ALL_MISSING;
    else if (msum_q < 0 && !cfg_i.allow_negative_mean) judge = ST_NEG_MEAN;
    else if (msum_q == 64'sd0) judge = ST_ZERO_MEAN;
    else judge = ST_OK;
  end

  // restoring divider, one quotient bit per cycle
  logic [63:0] dn_q, dd_q, rem_q;
  logic [40:0] q_q;
  logic [6:0]  cnt_q;
  logic        dneg_q;
  logic        dbit, dge;
  logic [64:0] rem_sh;
  logic [41:0] q_sh, qf;
  logic        rup;
  logic signed [31:0] div_res;
  status_e     status_q;

  always_comb begin
    dbit   = (cnt_q >= 7'd24) ? dn_q[63] : 1'b0;
    rem_sh = {rem_q, dbit};
    dge    = rem_sh >= {1'b0, dd_q};
    q_sh   = {q_q, dge};
    rup    = rem_q >= (dd_q - rem_q);
    qf     = {1'b0, q_q} + {41'd0, rup};
    if (dneg_q) begin
      div_res = (qf > 42'h0_8000_0000) ? 32'sh8000_0000 : 32'(42'd0 - qf);
    end else begin
      div_res = (qf > 42'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : qf[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dn_q   <= rsum_q[63] ? (64'd0 - rsum_q) : rsum_q;
      dd_q   <= msum_q[63] ? (64'd0 - msum_q) : msum_q;
      dneg_q <= rsum_q[63] ^ msum_q[63];
      rem_q  <= '0;
      q_q    <= '0;
      cnt_q  <= DivSteps;
    end
    if (cmd_i.div_step) begin
      if (cnt_q >= 7'd24) dn_q <= dn_q << 1;
      rem_q <= dge ? 64'(rem_sh - {1'b0, dd_q}) : rem_sh[63:0];
      q_q   <= (q_sh > {1'b0, QuotCap}) ? QuotCap : q_sh[40:0];
      cnt_q <= cnt_q - 7'd1;
    end
  end

  // factor and status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= FactorOne;
      status_q <= ST_OK;
    end else if (cmd_i.judge_fix) begin
      factor_q <= FactorOne;
      status_q <= judge;
    end else if (cmd_i.div_end) begin
      factor_q <= div_res;
      status_q <= ST_OK;
    end
  end

  // output register
  logic out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      result_kind_o  <= (mode_q != MODE_SCALE);
      scaled_real_o  <= (mode_q == MODE_SCALE) ? res_re_q : 32'sd0;
      scaled_imag_o  <= (mode_q == MODE_SCALE) ? res_im_q : 32'sd0;
      scale_factor_o <= factor_q;
      status_o       <= (mode_q == MODE_SCALE) ? ST_OK : status_q;
    end
  end

  assign out_valid_o = out_vld_q;

  always_comb begin
    sts_o                 = '0;
    sts_o.mode            = mode_q;
    sts_o.last            = last_q;
    sts_o.complex_samples = cfg_i.complex_samples;
    sts_o.sqrt_last       = sq_bit_q[0];
    sts_o.judge_ok        = (judge == ST_OK);
    sts_o.div_last        = (cnt_q == 7'd0);
    sts_o.out_free        = !out_vld_q || out_ready_i;
  end

  // a finishing voxel returns the position to the origin
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.acc && last_q |=> col_q == '0 && row_q == '0 && slc_q == '0)
    else $error("position not cleared after last voxel");

  // a fallback outcome always carries unit factor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q != ST_OK |-> factor_q == FactorOne)
    else $error("fallback status with non-unit factor");

  // result is never overwritten while waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !out_vld_q || out_ready_i)
    else $error("result overwritten");

endmodule

@@ rtl/core/central_region_mean_normalizer.sv @@
// Central-box intensity normalizer. Mode 0 voxels of a reference volume build one
// box sum per slice; mode 1 voxels of a volume sum its box (magnitude when complex)
// over slices not flagged in the missing mask and, on the voxel marked tlast, return
// one outcome item with the new Q8.24 factor and a status; mode 2 voxels come back
// multiplied by the factor, rounded and saturated. One item is in work at a time.
// A complex reference or measure voxel forms two products through the shared 32x32
// multiplier and takes a 32-step square root, a scale voxel may wait for the result
// register, and the final measure voxel runs the bit-serial 88-step divider unless
// its outcome is a fallback status.
module central_region_mean_normalizer (
  input  logic         clk_i,
  input  logic         rst_ni,
  // stream in
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // sample_real, sample_imag, slice_missing_mask
  input  logic [1:0]   s_axis_tuser,  // mode
  input  logic         s_axis_tlast,
  // stream out
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,  // scaled_real, scaled_imag, scale_factor, status
  output logic         m_axis_tuser,  // result_kind
  // register port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import crmn_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;
  logic signed [31:0] sc_re, sc_im, sc_fac;
  status_e sc_st;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.size_x              <= 9'd64;
      cfg_q.size_y              <= 9'd64;
      cfg_q.size_z              <= 7'd32;
      cfg_q.complex_samples     <= 1'b0;
      cfg_q.allow_negative_mean <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        RegSizeX:    cfg_q.size_x              <= pwdata[8:0];
        RegSizeY:    cfg_q.size_y              <= pwdata[8:0];
        RegSizeZ:    cfg_q.size_z              <= pwdata[6:0];
        RegComplex:  cfg_q.complex_samples     <= pwdata[0];
        RegAllowNeg: cfg_q.allow_negative_mean <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[4:2])
      RegSizeX:    prdata = {23'd0, cfg_q.size_x};
      RegSizeY:    prdata = {23'd0, cfg_q.size_y};
      RegSizeZ:    prdata = {25'd0, cfg_q.size_z};
      RegComplex:  prdata = {31'd0, cfg_q.complex_samples};
      RegAllowNeg: prdata = {31'd0, cfg_q.allow_negative_mean};
      default:     prdata = 32'd0;
    endcase
  end

  assign pready = 1'b1;

  crmn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  crmn_datapath u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .cfg_i                (cfg_q),
    .mode_i               (mode_e'(s_axis_tuser)),
    .sample_real_i        (s_axis_tdata[31:0]),
    .sample_imag_i        (s_axis_tdata[63:32]),
    .slice_missing_mask_i (s_axis_tdata[127:64]),
    .last_voxel_i         (s_axis_tlast),
    .out_valid_o          (m_axis_tvalid),
    .out_ready_i          (m_axis_tready),
    .result_kind_o        (m_axis_tuser),
    .scaled_real_o        (sc_re),
    .scaled_imag_o        (sc_im),
    .scale_factor_o       (sc_fac),
    .status_o             (sc_st)
  );

  // pack result fields
  assign m_axis_tdata = {6'd0, sc_st, sc_fac, sc_im, sc_re};

endmodule
